FILE: hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("mbfe port check failed");

// condition in one cycle implies a condition in the next
`define CHK_IMPLY_NEXT(lbl, clk, rst_n, a, b) \
    `CHK_ASSERT(lbl, clk, rst_n, (a) |=> (b))

`endif

FILE: hdl/mbfe_pkg.sv
// shared constants, codes and helpers of the mark bitmap forwarding engine
package mbfe_pkg;

    localparam int unsigned WORD_BITS_DEF    = 64;
    localparam int unsigned BITMAP_WORDS_DEF = 1024;
    localparam int unsigned MAX_WORD_BITS    = 64;
    localparam int unsigned POP_W            = 7;

    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned RES_W    = 17;
    localparam logic [RES_W-1:0] SUM_MAX = 17'h1FFFF;

    // s_tdata: unit_index, run_length; s_tuser: action, precise_root
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned S_TUSER_W = 3;
    // m_tdata: result_index; m_tuser: error_flag
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = 1;

    localparam logic [1:0] ACT_MARK     = 2'd0;
    localparam logic [1:0] ACT_FINALIZE = 2'd1;
    localparam logic [1:0] ACT_QUERY    = 2'd2;
    localparam logic [1:0] ACT_CLEAR    = 2'd3;

    function automatic logic [POP_W-1:0] popcount64(input logic [MAX_WORD_BITS-1:0] v);
        logic [POP_W-1:0] lvl [MAX_WORD_BITS];
        for (int i = 0; i < MAX_WORD_BITS; i++) begin
            lvl[i] = POP_W'(v[i]);
        end
        // pairwise adder tree, one level per doubling of the stride
        for (int step = 1; step < MAX_WORD_BITS; step = step * 2) begin
            for (int i = 0; i < MAX_WORD_BITS; i = i + 2 * step) begin
                lvl[i] = lvl[i] + lvl[i + step];
            end
        end
        return lvl[0];
    endfunction

endpackage

FILE: hdl/mark_bitmap_forwarding_engine_top.sv
// mark bitmap forwarding engine: sequencer, shared divider and bitmap/sum memories
//
// One word in, one word out, one at a time; s_tready is high only when idle.
// A constant reciprocal divider (multiply stage plus correction stage) splits
// the unit index into bitmap word and bit; marks then read-modify-write one
// bitmap word at a time (read state, then write state), finalize reads and
// sums the bitmap word by word, an in-place query or a dropped mark goes
// straight to the result, and clear sweeps every bitmap word, all bound by
// the single-port bitmap memory. After reset the bitmap is swept to zero, one
// word a cycle, before the first word is taken; the mode register can be
// written at any time the block is idle.
module mark_bitmap_forwarding_engine_top
    import mbfe_pkg::*;
#(
    parameter int unsigned WORD_BITS    = WORD_BITS_DEF,
    parameter int unsigned BITMAP_WORDS = BITMAP_WORDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,     // compacting_mode
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // unit_index[15:0], run_length[32:16]
    input  logic [S_TUSER_W-1:0] s_tuser,      // action[1:0], precise_root[2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // result_index[16:0]
    output logic [M_TUSER_W-1:0] m_tuser       // error_flag[0]
);

    localparam int unsigned AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned PW  = $clog2(WORD_BITS);
    localparam int unsigned SHW = $clog2(WORD_BITS + 1);
    localparam int unsigned TOTAL_UNITS = WORD_BITS * BITMAP_WORDS;
    localparam logic [31:0] TOTAL_32   = 32'(TOTAL_UNITS);
    localparam logic [16:0] TOTAL_LO   = 17'(TOTAL_UNITS);
    localparam logic [16:0] WORDS_17   = 17'(BITMAP_WORDS);
    localparam logic [16:0] WB_17      = 17'(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(BITMAP_WORDS - 1);
    localparam int unsigned DIV_SHIFT  = 24;
    localparam int unsigned RECIP_W    = 22;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'(1) << DIV_SHIFT) / WORD_BITS);
    localparam int unsigned PROD_W     = 17 + RECIP_W;
    localparam logic [WORD_BITS-1:0] ONES = '1;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DIV1 = 4'd2;
    localparam logic [3:0] ST_DIV2 = 4'd3;
    localparam logic [3:0] ST_MRD  = 4'd4;
    localparam logic [3:0] ST_MWR  = 4'd5;
    localparam logic [3:0] ST_FRD  = 4'd6;
    localparam logic [3:0] ST_FACC = 4'd7;
    localparam logic [3:0] ST_QRD  = 4'd8;
    localparam logic [3:0] ST_QRES = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic               mode_reg;
    logic [1:0]         action_reg, action_next;
    logic [16:0]        num_reg, num_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [16:0]        q_reg, q_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [16:0]        nwords_reg, nwords_next;
    logic [16:0]        rem_reg, rem_next;
    logic [16:0]        count_reg, count_next;
    logic               err_reg, err_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic               clr_reply_reg, clr_reply_next;
    logic               m_valid_reg, m_valid_next;
    logic [RES_W-1:0]   m_res_reg;
    logic               m_err_reg;

    logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
    logic [RES_W-1:0]     sums_mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0] bm_rdata_reg;
    logic [RES_W-1:0]     sm_rdata_reg;
    logic                 bm_we, sm_we;
    logic [WORD_BITS-1:0] bm_wdata;

    // input word fields
    logic [UNIT_W-1:0] in_unit;
    logic [LEN_W-1:0]  in_len;
    logic [1:0]        in_action;
    logic              in_precise;
    logic [16:0]       in_end;

    // divider correction
    logic [16:0] q0, r0;

    // mark masking
    logic [SHW-1:0]       span, ep;
    logic                 last_chunk;
    logic [WORD_BITS-1:0] run_mask;

    // finalize and query
    logic [POP_W-1:0]     pop_all, pop_pre;
    logic [17:0]          sum_wide;
    logic [PW-1:0]        bit_idx;
    logic                 load_out;

    assign in_unit    = s_tdata[15:0];
    assign in_len     = s_tdata[32:16];
    assign in_action  = s_tuser[1:0];
    assign in_precise = s_tuser[2];
    assign in_end     = {1'b0, in_unit} + in_len;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = M_TDATA_W'(m_res_reg);
    assign m_tuser   = m_err_reg;

    // constant reciprocal: estimate is exact or one short
    assign q0 = 17'(prod_reg >> DIV_SHIFT);
    assign r0 = num_reg - 17'(q0 * WB_17);

    assign span       = SHW'(WORD_BITS) - SHW'(pos_reg);
    assign last_chunk = (rem_reg <= 17'(span));
    assign ep         = last_chunk ? (SHW'(pos_reg) + rem_reg[SHW-1:0]) : SHW'(WORD_BITS);
    assign run_mask   = (ONES >> pos_reg) & ~(ONES >> ep);

    assign pop_all  = popcount64(MAX_WORD_BITS'(bm_rdata_reg));
    assign pop_pre  = popcount64(MAX_WORD_BITS'(bm_rdata_reg & ~(ONES >> pos_reg)));
    assign sum_wide = {1'b0, count_reg} + 18'(pop_all);
    assign bit_idx  = PW'(WORD_BITS - 1) - pos_reg;

    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        bm_we    = 1'b0;
        sm_we    = 1'b0;
        bm_wdata = '0;
        if (state_reg == ST_MWR) begin
            bm_we    = 1'b1;
            bm_wdata = bm_rdata_reg | run_mask;
        end else if (state_reg == ST_CLR) begin
            bm_we = 1'b1;
        end
        if (state_reg == ST_FACC) begin
            sm_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bitmap_mem[ptr_reg] <= bm_wdata;
        end
        bm_rdata_reg <= bitmap_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (sm_we) begin
            sums_mem[ptr_reg] <= count_reg;
        end
        sm_rdata_reg <= sums_mem[ptr_reg];
    end

    always_comb begin
        state_next     = state_reg;
        action_next    = action_reg;
        num_next       = num_reg;
        q_next         = q_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        nwords_next    = nwords_reg;
        rem_next       = rem_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        res_next       = res_reg;
        clr_reply_next = clr_reply_reg;
        case (state_reg)
            ST_CLR: begin
                if (ptr_reg == LAST_WORD) begin
                    ptr_next   = '0;
                    state_next = clr_reply_reg ? ST_OUT : ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    action_next = in_action;
                    err_next    = 1'b0;
                    res_next    = '0;
                    num_next    = {1'b0, in_unit};
                    case (in_action)
                        ACT_MARK: begin
                            if (mode_reg && (!in_precise || in_len == '0)) begin
                                state_next = ST_OUT;
                            end else if (32'(in_unit) >= TOTAL_32) begin
                                err_next   = 1'b1;
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_DIV1;
                                if (!mode_reg) begin
                                    rem_next = 17'd1;
                                end else if (32'(in_end) > TOTAL_32) begin
                                    err_next = 1'b1;
                                    rem_next = TOTAL_LO - {1'b0, in_unit};
                                end else begin
                                    rem_next = in_len;
                                end
                            end
                        end
                        ACT_FINALIZE: begin
                            num_next   = {1'b0, in_unit} + (WB_17 - 17'd1);
                            state_next = ST_DIV1;
                        end
                        ACT_QUERY: begin
                            if (!mode_reg) begin
                                res_next   = {1'b0, in_unit};
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_DIV1;
                            end
                        end
                        default: begin
                            ptr_next       = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLR;
                        end
                    endcase
                end
            end
            ST_DIV1: begin
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                if (r0 >= WB_17) begin
                    q_next   = q0 + 17'd1;
                    pos_next = PW'(r0 - WB_17);
                end else begin
                    q_next   = q0;
                    pos_next = PW'(r0);
                end
                case (action_reg)
                    ACT_MARK: begin
                        ptr_next   = AW'(q_next);
                        state_next = ST_MRD;
                    end
                    ACT_FINALIZE: begin
                        nwords_next = (q_next > WORDS_17) ? WORDS_17 : q_next;
                        ptr_next    = '0;
                        count_next  = '0;
                        state_next  = (nwords_next == '0) ? ST_OUT : ST_FRD;
                    end
                    default: begin
                        if (q_next >= WORDS_17) begin
                            err_next   = 1'b1;
                            state_next = ST_OUT;
                        end else begin
                            ptr_next   = AW'(q_next);
                            state_next = ST_QRD;
                        end
                    end
                endcase
            end
            ST_MRD: begin
                state_next = ST_MWR;
            end
            ST_MWR: begin
                if (last_chunk) begin
                    state_next = ST_OUT;
                end else begin
                    rem_next   = rem_reg - 17'(span);
                    pos_next   = '0;
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_FRD: begin
                state_next = ST_FACC;
            end
            ST_FACC: begin
                if (sum_wide > 18'(SUM_MAX)) begin
                    count_next = SUM_MAX;
                    err_next   = 1'b1;
                end else begin
                    count_next = sum_wide[16:0];
                end
                if (17'(ptr_reg) + 17'd1 == nwords_reg) begin
                    res_next   = count_next;
                    state_next = ST_OUT;
                end else begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_FRD;
                end
            end
            ST_QRD: begin
                state_next = ST_QRES;
            end
            ST_QRES: begin
                res_next   = sm_rdata_reg + 17'(pop_pre);
                err_next   = !bm_rdata_reg[bit_idx];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (load_out) begin
                    clr_reply_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLR;
            ptr_reg       <= '0;
            clr_reply_reg <= 1'b0;
            mode_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        num_reg    <= num_next;
        prod_reg   <= PROD_W'(num_reg) * PROD_W'(RECIP);
        q_reg      <= q_next;
        pos_reg    <= pos_next;
        nwords_reg <= nwords_next;
        rem_reg    <= rem_next;
        count_reg  <= count_next;
        err_reg    <= err_next;
        res_reg    <= res_next;
        if (load_out) begin
            m_res_reg <= res_reg;
            m_err_reg <= err_reg;
        end
    end

endmodule

FILE: hdl/mbfe_checker.sv
// port-level checks of the mark bitmap forwarding engine, bound to the top level
`include "assert_macros.svh"

module mbfe_checker
    import mbfe_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 cfg_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // a stalled result word holds
    `CHK_IMPLY_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one word at a time: the input closes right after a word is taken
    `CHK_IMPLY_NEXT(a_in_closes, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a fresh result only appears while the input side is busy
    `CHK_ASSERT(a_out_from_busy, aclk, aresetn, $rose(m_tvalid) |-> !$past(s_tready))

    // mode writes are never back-pressured
    `CHK_ASSERT(a_cfg_open, aclk, aresetn, cfg_valid |-> cfg_ready)

endmodule

bind mark_bitmap_forwarding_engine_top mbfe_checker u_mbfe_checker (.*);
